[rtl/core/rc4sc_pkg.sv]
package rc4sc_pkg;

  // Permutation table geometry.
  localparam int unsigned PermAw = 8;

  // Configuration register indexes.
  localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [1:0] CFG_KEY_LEN  = 2'd2;

  // Key length after reset.
  localparam logic [4:0] KeyLenReset = 5'd16;

  // Sequencer states: key schedule fill, key schedule swap, keystream step.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KSA_INIT,
    ST_KSA_RD_N,
    ST_KSA_RD_A,
    ST_KSA_WR_N,
    ST_KSA_WR_A,
    ST_PRGA_I,
    ST_PRGA_J,
    ST_PRGA_WI,
    ST_PRGA_WJ,
    ST_PRGA_KS
  } rc4sc_state_e;

  // One access request to the permutation memory.
  typedef struct packed {
    logic              we;
    logic [PermAw-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [PermAw-1:0] raddr;
  } perm_req_t;

  // Select one key byte from the two key words.
  function automatic logic [7:0] key_byte(input logic [63:0] lo, input logic [63:0] hi,
                                          input logic [3:0] k);
    logic [63:0] word;
    word = k[3] ? hi : lo;
    return word[{k[2:0], 3'b000} +: 8];
  endfunction

endpackage

[rtl/core/rc4sc_perm_ram.sv]
module rc4sc_perm_ram
  import rc4sc_pkg::*;
(
  input  logic        clk_i,
  input  perm_req_t   req_i,
  output logic [7:0]  rdata_o
);

  logic [7:0] mem [2**PermAw];
  logic [7:0] rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/rc4_stream_cipher_core.sv]
// RC4 stream cipher core: each input word returns one output word, data XOR keystream.
// Without a key schedule, a word passes PRGA_I, PRGA_J, PRGA_WI, PRGA_WJ and PRGA_KS, set by
// the dependent read, swap and keystream read steps on the permutation memory, before output
// valid rises; the next word is taken only after that, later while a result waits.
// A word flagged as first of message, or the first word after reset, adds a key schedule: a
// fill of 256 entries, then 256 swap steps via KSA_RD_N, KSA_RD_A, KSA_WR_N, KSA_WR_A.
// Reset clears the indexes and key registers, sets the key length to 16 and forces a key schedule.
module rc4_stream_cipher_core
  import rc4sc_pkg::*;
#(
  parameter int unsigned MAX_KEY_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] first_of_message
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [7:0] out_byte
);

  rc4sc_state_e state_q, state_d;

  logic [63:0] key_lo_q, key_hi_q;
  logic [4:0]  key_len_q;

  logic [7:0] cnt_q, cnt_d;
  logic [3:0] kpos_q, kpos_d;
  logic [7:0] acc_q, acc_d;
  logic [7:0] held_q, held_d;
  logic [7:0] i_q, i_d;
  logic [7:0] j_q, j_d;
  logic       fwd_q, fwd_d;
  logic       needs_key_q, needs_key_d;
  logic [7:0] data_q;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_data_q, out_data_d;

  logic       in_acc;
  logic [4:0] eff_len;
  logic [4:0] kpos_inc;
  logic [7:0] tap;
  logic [7:0] rdata;
  perm_req_t  req;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Key length clamped to the legal range.
  always_comb begin
    eff_len = key_len_q;
    if (key_len_q == 5'd0) begin
      eff_len = 5'd1;
    end else if (key_len_q > 5'(MAX_KEY_BYTES)) begin
      eff_len = 5'(MAX_KEY_BYTES);
    end
  end

  assign kpos_inc = {1'b0, kpos_q} + 5'd1;
  assign tap      = held_q + rdata;

  rc4sc_perm_ram u_perm_ram (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q  <= '0;
      key_hi_q  <= '0;
      key_len_q <= KeyLenReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEY_LOW:  key_lo_q  <= cfg_wdata_i;
        CFG_KEY_HIGH: key_hi_q  <= cfg_wdata_i;
        CFG_KEY_LEN:  key_len_q <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      needs_key_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      needs_key_q <= needs_key_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    kpos_q     <= kpos_d;
    acc_q      <= acc_d;
    held_q     <= held_d;
    fwd_q      <= fwd_d;
    out_data_q <= out_data_d;
    if (in_acc) begin
      data_q <= s_axis_tdata;
    end
  end

  // Sequencer: next state, memory requests and output register.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    kpos_d      = kpos_q;
    acc_d       = acc_q;
    held_d      = held_q;
    i_d         = i_q;
    j_d         = j_q;
    fwd_d       = fwd_q;
    needs_key_d = needs_key_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    req         = '0;
    s_axis_tready = 1'b0;

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cnt_d   = '0;
          state_d = (s_axis_tuser || needs_key_q) ? ST_KSA_INIT : ST_PRGA_I;
        end
      end
      // Load the identity permutation, one entry a cycle.
      ST_KSA_INIT: begin
        req.we    = 1'b1;
        req.waddr = cnt_q;
        req.wdata = cnt_q;
        cnt_d     = cnt_q + 8'd1;
        if (cnt_q == 8'hff) begin
          acc_d   = '0;
          kpos_d  = '0;
          state_d = ST_KSA_RD_N;
        end
      end
      ST_KSA_RD_N: begin
        req.re    = 1'b1;
        req.raddr = cnt_q;
        state_d   = ST_KSA_RD_A;
      end
      // The entry at n has arrived; step the accumulator and fetch its entry.
      ST_KSA_RD_A: begin
        held_d    = rdata;
        acc_d     = acc_q + key_byte(key_lo_q, key_hi_q, kpos_q) + rdata;
        req.re    = 1'b1;
        req.raddr = acc_d;
        state_d   = ST_KSA_WR_N;
      end
      ST_KSA_WR_N: begin
        req.we    = 1'b1;
        req.waddr = cnt_q;
        req.wdata = rdata;
        state_d   = ST_KSA_WR_A;
      end
      ST_KSA_WR_A: begin
        req.we    = 1'b1;
        req.waddr = acc_q;
        req.wdata = held_q;
        cnt_d     = cnt_q + 8'd1;
        kpos_d    = (kpos_inc >= eff_len) ? 4'd0 : kpos_inc[3:0];
        if (cnt_q == 8'hff) begin
          i_d         = '0;
          j_d         = '0;
          needs_key_d = 1'b0;
          state_d     = ST_PRGA_I;
        end else begin
          state_d = ST_KSA_RD_N;
        end
      end
      // Keystream step: fetch S[i+1].
      ST_PRGA_I: begin
        i_d       = i_q + 8'd1;
        req.re    = 1'b1;
        req.raddr = i_d;
        state_d   = ST_PRGA_J;
      end
      ST_PRGA_J: begin
        held_d    = rdata;
        j_d       = j_q + rdata;
        req.re    = 1'b1;
        req.raddr = j_d;
        state_d   = ST_PRGA_WI;
      end
      ST_PRGA_WI: begin
        req.we    = 1'b1;
        req.waddr = i_q;
        req.wdata = rdata;
        state_d   = ST_PRGA_WJ;
      end
      // Finish the swap and fetch the keystream entry in the same cycle.
      // When that entry is the one written now, the written value is forwarded.
      ST_PRGA_WJ: begin
        req.we    = 1'b1;
        req.waddr = j_q;
        req.wdata = held_q;
        req.re    = 1'b1;
        req.raddr = tap;
        fwd_d     = (tap == j_q);
        state_d   = ST_PRGA_KS;
      end
      // Wait for the output register to be free, then load the result word.
      ST_PRGA_KS: begin
        if (!out_valid_q || m_axis_tready) begin
          out_data_d  = data_q ^ (fwd_q ? held_q : rdata);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[rtl/core/rc4sc_checker.sv]
module rc4sc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  logic [1:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Words accepted whose result has not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 2'd1;
    end
  end

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // The core works on one word at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input accepted back to back");

  // At most one word in work plus one waiting result.
  a_pending_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("too many words outstanding");

  // No result word without an accepted input word.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pending_q != 2'd0)
    else $error("result word without input word");

endmodule

bind rc4_stream_cipher_core rc4sc_checker u_rc4sc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
